// File: hdl/rv64i_itype_execute_top_defines.svh
// ---------------------------------------------------------------------------
// rv64i_itype_execute_top_defines
// assertion macros for the i-type execute unit
// ---------------------------------------------------------------------------
`ifndef RV64I_ITYPE_EXECUTE_TOP_DEFINES_SVH
`define RV64I_ITYPE_EXECUTE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RIE_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RIE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rie_pkg.sv
// ---------------------------------------------------------------------------
// rie_pkg
// types and codes shared by the rv64i i-type execute unit
// ---------------------------------------------------------------------------
package rie_pkg;

  localparam logic [6:0] OPC_OP_IMM    = 7'h13;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
  localparam logic [6:0] OPC_LOAD      = 7'h03;
  localparam logic [6:0] OPC_JALR      = 7'h67;
  localparam logic [6:0] OPC_SYSTEM    = 7'h73;
  localparam logic [6:0] OPC_MISC_MEM  = 7'h0F;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_ECALL   = 3'd2;
  localparam logic [2:0] ST_EBREAK  = 3'd3;
  localparam logic [2:0] ST_FENCE   = 3'd4;

  typedef struct packed {
    logic [6:0]         opcode;
    logic [2:0]         funct3;
    logic [4:0]         dest_index;
    logic [4:0]         src_index;
    logic signed [11:0] immediate;
    logic [63:0]        src_value;
    logic [63:0]        pc_value;
    logic [63:0]        load_data;
  } rie_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        jump_taken;
    logic [63:0] jump_target;
    logic        mem_read;
    logic [63:0] mem_address;
    logic [1:0]  access_size;
    logic [2:0]  status;
  } rie_res_t;

endpackage

// File: hdl/rie_exec.sv
// ---------------------------------------------------------------------------
// rie_exec
// combinational decode and execute of one registered i-type instruction
// ---------------------------------------------------------------------------
module rie_exec (
  input  rie_pkg::rie_in_t  item,
  output rie_pkg::rie_res_t res
);
  import rie_pkg::*;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LD  = 3'd3;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_LWU = 3'd6;

  localparam logic [5:0]  SRAI_HI  = 6'b010000;
  localparam logic [6:0]  SRAIW_HI = 7'b0100000;
  localparam logic [11:0] IMM_EBREAK = 12'd1;
  localparam logic [63:0] LINK_STEP  = 64'd4;

  logic [63:0] imm64;
  logic [63:0] a;
  logic [63:0] sum;
  logic [31:0] w_shl;
  logic [31:0] w_shr;
  logic [63:0] a32_sext;
  logic [5:0]  hi6;
  logic [6:0]  hi7;
  logic [5:0]  sh6;
  logic [4:0]  sh5;
  logic [63:0] ld;
  logic        wr;
  logic        jmp;
  logic        rdm;
  logic [63:0] val;
  logic [2:0]  st;
  logic        wen;

  assign imm64    = {{52{item.immediate[11]}}, item.immediate};
  assign a        = item.src_value;
  assign sum      = a + imm64;
  assign hi6      = item.immediate[11:6];
  assign hi7      = item.immediate[11:5];
  assign sh6      = item.immediate[5:0];
  assign sh5      = item.immediate[4:0];
  assign w_shl    = a[31:0] << sh5;
  assign w_shr    = a[31:0] >> sh5;
  assign a32_sext = {{32{a[31]}}, a[31:0]};
  assign ld       = item.load_data;

  always_comb begin
    wr  = 1'b0;
    jmp = 1'b0;
    rdm = 1'b0;
    val = '0;
    st  = ST_OK;
    case (item.opcode)
      OPC_OP_IMM: begin
        wr = 1'b1;
        case (item.funct3)
          F3_ADD:  val = sum;
          F3_SLL: begin
            if (hi6 == '0) val = a << sh6;
            else st = ST_ILLEGAL;
          end
          F3_SLT:  val = {63'd0, $signed(a) < $signed(imm64)};
          F3_SLTU: val = {63'd0, a < imm64};
          F3_XOR:  val = a ^ imm64;
          F3_SRL: begin
            if (hi6 == SRAI_HI) val = $unsigned($signed(a) >>> sh6);
            else if (hi6 == '0) val = a >> sh6;
            else st = ST_ILLEGAL;
          end
          F3_OR:   val = a | imm64;
          F3_AND:  val = a & imm64;
          default: val = a & imm64;
        endcase
      end
      OPC_OP_IMM_32: begin
        wr = 1'b1;
        case (item.funct3)
          F3_ADD:  val = {{32{sum[31]}}, sum[31:0]};
          F3_SLL: begin
            if (hi7 == '0) val = {{32{w_shl[31]}}, w_shl};
            else st = ST_ILLEGAL;
          end
          F3_SRL: begin
            if (hi7 == SRAIW_HI) val = $unsigned($signed(a32_sext) >>> sh5);
            else if (hi7 == '0) val = {{32{w_shr[31]}}, w_shr};
            else st = ST_ILLEGAL;
          end
          default: st = ST_ILLEGAL;
        endcase
      end
      OPC_LOAD: begin
        wr  = 1'b1;
        rdm = 1'b1;
        case (item.funct3)
          F3_LB:   val = {{56{ld[7]}}, ld[7:0]};
          F3_LH:   val = {{48{ld[15]}}, ld[15:0]};
          F3_LW:   val = {{32{ld[31]}}, ld[31:0]};
          F3_LD:   val = ld;
          F3_LBU:  val = {56'd0, ld[7:0]};
          F3_LHU:  val = {48'd0, ld[15:0]};
          F3_LWU:  val = {32'd0, ld[31:0]};
          default: st = ST_ILLEGAL;
        endcase
      end
      OPC_JALR: begin
        if (item.funct3 != F3_ADD) begin
          st = ST_ILLEGAL;
        end else begin
          wr  = 1'b1;
          jmp = 1'b1;
          val = item.pc_value + LINK_STEP;
        end
      end
      OPC_SYSTEM: begin
        if (item.src_index != '0 || item.dest_index != '0 || item.funct3 != '0) begin
          st = ST_ILLEGAL;
        end else if (item.immediate == '0) begin
          st = ST_ECALL;
        end else if (item.immediate == IMM_EBREAK) begin
          st = ST_EBREAK;
        end else begin
          st = ST_ILLEGAL;
        end
      end
      OPC_MISC_MEM: st = ST_FENCE;
      default:      st = ST_ILLEGAL;
    endcase
  end

  always_comb begin
    wen              = wr && (st != ST_ILLEGAL) && (item.dest_index != '0);
    res.write_enable = wen;
    res.write_index  = item.dest_index;
    res.write_value  = wen ? val : '0;
    res.jump_taken   = jmp && (st != ST_ILLEGAL);
    res.jump_target  = res.jump_taken ? {sum[63:1], 1'b0} : '0;
    res.mem_read     = rdm && (st != ST_ILLEGAL);
    res.mem_address  = res.mem_read ? sum : '0;
    res.access_size  = res.mem_read ? item.funct3[1:0] : '0;
    res.status       = st;
  end

endmodule

// File: hdl/rv64i_itype_execute_top.sv
// ---------------------------------------------------------------------------
// rv64i_itype_execute_top
// rv64i i-type execute unit: op-imm, op-imm-32, loads, jalr, system, fence
// ---------------------------------------------------------------------------
//  channel   handshake          transfer when            payload
//  input     start / busy       start && !busy           in_* instruction fields
//  result    out_valid strobe   every cycle out_valid    out_* result fields
//
//  one instruction per clock; busy is always low
//  each transfer passes the input register, then
//  decode / 64-bit add / shifter ahead of the result register
//  synchronous reset clears the valid bits; payload registers are not reset
//  no stall path: each result is shown for exactly one cycle
// ---------------------------------------------------------------------------
`include "rv64i_itype_execute_top_defines.svh"

module rv64i_itype_execute_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [6:0]         in_opcode,
  input  logic [2:0]         in_funct3,
  input  logic [4:0]         in_dest_index,
  input  logic [4:0]         in_src_index,
  input  logic signed [11:0] in_immediate,
  input  logic [63:0]        in_src_value,
  input  logic [63:0]        in_pc_value,
  input  logic [63:0]        in_load_data,
  output logic               out_valid,
  output logic               out_write_enable,
  output logic [4:0]         out_write_index,
  output logic [63:0]        out_write_value,
  output logic               out_jump_taken,
  output logic [63:0]        out_jump_target,
  output logic               out_mem_read,
  output logic [63:0]        out_mem_address,
  output logic [1:0]         out_access_size,
  output logic [2:0]         out_status
);
  import rie_pkg::*;

  logic     in_valid_r;
  logic     in_valid_nxt;
  rie_in_t  in_item_r;
  rie_res_t res_nxt;
  rie_res_t res_r;
  logic     res_valid_r;

  assign busy         = 1'b0;
  assign in_valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r.opcode     <= in_opcode;
      in_item_r.funct3     <= in_funct3;
      in_item_r.dest_index <= in_dest_index;
      in_item_r.src_index  <= in_src_index;
      in_item_r.immediate  <= in_immediate;
      in_item_r.src_value  <= in_src_value;
      in_item_r.pc_value   <= in_pc_value;
      in_item_r.load_data  <= in_load_data;
    end
  end

  rie_exec u_exec (
    .item (in_item_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_write_enable = res_r.write_enable;
  assign out_write_index  = res_r.write_index;
  assign out_write_value  = res_r.write_value;
  assign out_jump_taken   = res_r.jump_taken;
  assign out_jump_target  = res_r.jump_target;
  assign out_mem_read     = res_r.mem_read;
  assign out_mem_address  = res_r.mem_address;
  assign out_access_size  = res_r.access_size;
  assign out_status       = res_r.status;

  `RIE_ASSERT_NEXT(a_latency, start && !busy, ##1 out_valid, "result strobe missing")
  `RIE_ASSERT_SAME(a_illegal_quiet, out_valid && out_status == ST_ILLEGAL,
    !out_write_enable && !out_jump_taken && !out_mem_read, "illegal result has side effects")
  `RIE_ASSERT_SAME(a_no_x0_write, out_valid && out_write_enable,
    out_write_index != 5'd0, "write to x0")
  `RIE_ASSERT_SAME(a_strobe_source, out_valid, $past(in_valid_r), "result without transfer")

endmodule

// File: test/itype_check_pkg.sv
// ---------------------------------------------------------------------------
// itype_check_pkg
// expected-result tracking for the rv64i i-type execute unit: each
// instruction transfer is executed in software and the result queued, and
// each result transfer is compared field by field with the oldest entry
// ---------------------------------------------------------------------------
package itype_check_pkg;

  import rie_pkg::*;

  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;

  localparam logic [2:0] F3_LB    = 3'd0;
  localparam logic [2:0] F3_LH    = 3'd1;
  localparam logic [2:0] F3_LW    = 3'd2;
  localparam logic [2:0] F3_LD    = 3'd3;
  localparam logic [2:0] F3_LBU   = 3'd4;
  localparam logic [2:0] F3_LHU   = 3'd5;
  localparam logic [2:0] F3_LWU   = 3'd6;
  localparam logic [2:0] F3_LRSVD = 3'd7;

  localparam logic [2:0] F3_JALR  = 3'd0;
  localparam logic [2:0] F3_PRIV  = 3'd0;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_DBL  = 2'd3;

  localparam logic [5:0]  SRA_HI6    = 6'b010000;
  localparam logic [6:0]  SRA_HI7    = 7'b0100000;
  localparam logic [11:0] IMM_ECALL  = 12'd0;
  localparam logic [11:0] IMM_EBREAK = 12'd1;

  class itype_scoreboard;

    rie_res_t expected_results[$];
    int       errors;
    int       results_seen;

    function logic [63:0] sext32(logic [31:0] x);
      return {{32{x[31]}}, x};
    endfunction

    function rie_res_t execute_insn(rie_in_t insn);
      rie_res_t    res;
      logic [63:0] imm, a, ld, sum, val, tgt, addr;
      logic [1:0]  size;
      logic [2:0]  st;
      logic        wr, jmp, rdm;
      logic [5:0]  hi6, sh6;
      logic [6:0]  hi7;
      logic [4:0]  sh5;
      imm  = {{52{insn.immediate[11]}}, insn.immediate};
      a    = insn.src_value;
      ld   = insn.load_data;
      sum  = a + imm;
      hi6  = insn.immediate[11:6];
      hi7  = insn.immediate[11:5];
      sh6  = insn.immediate[5:0];
      sh5  = insn.immediate[4:0];
      wr   = 1'b0;
      jmp  = 1'b0;
      rdm  = 1'b0;
      val  = '0;
      tgt  = '0;
      addr = '0;
      size = SIZE_BYTE;
      st   = ST_OK;
      case (insn.opcode)
        OPC_OP_IMM: begin
          wr = 1'b1;
          case (insn.funct3)
            F3_ADDI:  val = sum;
            F3_SLLI:  if (hi6 == 6'd0) val = a << sh6; else st = ST_ILLEGAL;
            F3_SLTI:  val = ($signed(a) < $signed(imm)) ? 64'd1 : 64'd0;
            F3_SLTIU: val = (a < imm) ? 64'd1 : 64'd0;
            F3_XORI:  val = a ^ imm;
            F3_SRXI: begin
              if (hi6 == SRA_HI6) val = $signed(a) >>> sh6;
              else if (hi6 == 6'd0) val = a >> sh6;
              else st = ST_ILLEGAL;
            end
            F3_ORI:   val = a | imm;
            default:  val = a & imm;
          endcase
        end
        OPC_OP_IMM_32: begin
          wr = 1'b1;
          case (insn.funct3)
            F3_ADDI: val = sext32(a[31:0] + imm[31:0]);
            F3_SLLI: if (hi7 == 7'd0) val = sext32(a[31:0] << sh5); else st = ST_ILLEGAL;
            F3_SRXI: begin
              if (hi7 == SRA_HI7) val = sext32($signed(a[31:0]) >>> sh5);
              else if (hi7 == 7'd0) val = sext32(a[31:0] >> sh5);
              else st = ST_ILLEGAL;
            end
            default: st = ST_ILLEGAL;
          endcase
        end
        OPC_LOAD: begin
          if (insn.funct3 == F3_LRSVD) begin
            st = ST_ILLEGAL;
          end else begin
            wr   = 1'b1;
            rdm  = 1'b1;
            addr = sum;
            size = insn.funct3[1:0];
            case (size)
              SIZE_BYTE: val = insn.funct3[2] ? {56'd0, ld[7:0]}  : {{56{ld[7]}}, ld[7:0]};
              SIZE_HALF: val = insn.funct3[2] ? {48'd0, ld[15:0]} : {{48{ld[15]}}, ld[15:0]};
              SIZE_WORD: val = insn.funct3[2] ? {32'd0, ld[31:0]} : sext32(ld[31:0]);
              default:   val = ld;
            endcase
          end
        end
        OPC_JALR: begin
          if (insn.funct3 != F3_JALR) begin
            st = ST_ILLEGAL;
          end else begin
            wr  = 1'b1;
            jmp = 1'b1;
            val = insn.pc_value + 64'd4;
            tgt = {sum[63:1], 1'b0};
          end
        end
        OPC_SYSTEM: begin
          if (insn.src_index != 5'd0 || insn.dest_index != 5'd0 || insn.funct3 != F3_PRIV)
            st = ST_ILLEGAL;
          else if (insn.immediate == IMM_ECALL)
            st = ST_ECALL;
          else if (insn.immediate == IMM_EBREAK)
            st = ST_EBREAK;
          else
            st = ST_ILLEGAL;
        end
        OPC_MISC_MEM: st = ST_FENCE;
        default:      st = ST_ILLEGAL;
      endcase
      if (st == ST_ILLEGAL) begin
        wr   = 1'b0;
        jmp  = 1'b0;
        rdm  = 1'b0;
        val  = '0;
        tgt  = '0;
        addr = '0;
        size = SIZE_BYTE;
      end
      res.write_enable = wr && (insn.dest_index != 5'd0);
      res.write_index  = insn.dest_index;
      res.write_value  = res.write_enable ? val : 64'd0;
      res.jump_taken   = jmp;
      res.jump_target  = tgt;
      res.mem_read     = rdm;
      res.mem_address  = addr;
      res.access_size  = size;
      res.status       = st;
      return res;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function void note_issue(rie_in_t insn);
      expected_results.push_back(execute_insn(insn));
    endfunction

    task check_result(rie_res_t got);
      rie_res_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("result transfer with no instruction outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("write_enable", got.write_enable, want.write_enable);
        compare_field("write_index",  got.write_index,  want.write_index);
        compare_field("write_value",  got.write_value,  want.write_value);
        compare_field("jump_taken",   got.jump_taken,   want.jump_taken);
        compare_field("jump_target",  got.jump_target,  want.jump_target);
        compare_field("mem_read",     got.mem_read,     want.mem_read);
        compare_field("mem_address",  got.mem_address,  want.mem_address);
        compare_field("access_size",  got.access_size,  want.access_size);
        compare_field("status",       got.status,       want.status);
      end
    endtask

  endclass

endpackage

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// testbench for the rv64i i-type execute unit: a directed set of encodings
// and corner values, then biased random instructions with random gaps on
// the instruction side; every result transfer is checked in order
// ---------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rie_pkg::*;
  import itype_check_pkg::*;

  localparam int RANDOM_ITEMS = 930;
  localparam int QUIET_FROM   = 830;
  localparam int IDLE_LIMIT   = 200;
  localparam int DRAIN_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  rie_in_t stim;
  logic out_valid;
  rie_res_t res;

  itype_scoreboard sb;
  int unsigned idle_cycles;

  rv64i_itype_execute_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (stim.opcode),
    .in_funct3        (stim.funct3),
    .in_dest_index    (stim.dest_index),
    .in_src_index     (stim.src_index),
    .in_immediate     (stim.immediate),
    .in_src_value     (stim.src_value),
    .in_pc_value      (stim.pc_value),
    .in_load_data     (stim.load_data),
    .out_valid        (out_valid),
    .out_write_enable (res.write_enable),
    .out_write_index  (res.write_index),
    .out_write_value  (res.write_value),
    .out_jump_taken   (res.jump_taken),
    .out_jump_target  (res.jump_target),
    .out_mem_read     (res.mem_read),
    .out_mem_address  (res.mem_address),
    .out_access_size  (res.access_size),
    .out_status       (res.status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(res);
      if (start && !busy) sb.note_issue(stim);
    end
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return {rand_word() & 64'hFFFF_FFFF_0000_0000} | 64'h0000_0000_8000_0000;
      default: return rand_word();
    endcase
  endfunction

  function automatic rie_in_t make_insn(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm, logic [63:0] a,
                                        logic [63:0] pc, logic [63:0] ld);
    rie_in_t r;
    r.opcode     = opc;
    r.funct3     = f3;
    r.dest_index = rd;
    r.src_index  = rs1;
    r.immediate  = imm;
    r.src_value  = a;
    r.pc_value   = pc;
    r.load_data  = ld;
    return r;
  endfunction

  function automatic rie_in_t random_insn();
    rie_in_t r;
    int pick;
    pick         = $urandom_range(0, 99);
    r.funct3     = 3'($urandom_range(0, 7));
    r.dest_index = 5'($urandom_range(0, 31));
    r.src_index  = 5'($urandom_range(0, 31));
    r.src_value  = rand_operand();
    r.pc_value   = rand_word();
    r.load_data  = rand_word();
    case ($urandom_range(0, 7))
      0:       r.immediate = 12'h800;
      1:       r.immediate = 12'h7FF;
      2:       r.immediate = 12'h000;
      3:       r.immediate = 12'hFFF;
      default: r.immediate = 12'($urandom);
    endcase
    if (pick < 30) begin
      r.opcode = OPC_OP_IMM;
      if ((r.funct3 == F3_SLLI || r.funct3 == F3_SRXI) && $urandom_range(0, 9) < 8)
        r.immediate[11:6] = ($urandom_range(0, 1) == 0) ? 6'd0 : SRA_HI6;
    end else if (pick < 48) begin
      r.opcode = OPC_OP_IMM_32;
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 2))
          0:       r.funct3 = F3_ADDI;
          1:       r.funct3 = F3_SLLI;
          default: r.funct3 = F3_SRXI;
        endcase
      end
      if (r.funct3 != F3_ADDI && $urandom_range(0, 9) < 8)
        r.immediate[11:5] = ($urandom_range(0, 1) == 0) ? 7'd0 : SRA_HI7;
    end else if (pick < 68) begin
      r.opcode = OPC_LOAD;
    end else if (pick < 78) begin
      r.opcode = OPC_JALR;
      if ($urandom_range(0, 9) < 8) r.funct3 = F3_JALR;
    end else if (pick < 86) begin
      r.opcode = OPC_SYSTEM;
      if ($urandom_range(0, 9) < 7) begin
        r.funct3     = F3_PRIV;
        r.dest_index = 5'd0;
        r.src_index  = 5'd0;
        r.immediate  = ($urandom_range(0, 1) == 0) ? IMM_ECALL : IMM_EBREAK;
      end
    end else if (pick < 90) begin
      r.opcode = OPC_MISC_MEM;
    end else begin
      r.opcode = 7'($urandom);
    end
    return r;
  endfunction

  task automatic send_insn(rie_in_t insn);
    @(negedge clk);
    stim  <= insn;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    stim  <= random_insn();
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    rie_in_t directed[$];
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    stim        = '0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // op-imm extremes, shift encodings, destination x0
    directed.push_back(make_insn(OPC_OP_IMM, F3_ADDI, 5'd1, 5'd2, 12'h001, '1, 64'd0, 64'd0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SLLI, 5'd31, 5'd31, 12'h03F, 64'd1, '1, '1));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SLLI, 5'd3, 5'd4, 12'h403, 64'd5, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SLTI, 5'd5, 5'd6, 12'hFFF,
                                 64'h8000_0000_0000_0000, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SLTIU, 5'd7, 5'd8, 12'hFFF, 64'd5, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_XORI, 5'd9, 5'd10, 12'h800, rand_word(), 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SRXI, 5'd11, 5'd12, 12'h03F, '1, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SRXI, 5'd13, 5'd14, 12'h43F,
                                 64'h8000_0000_0000_0000, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_SRXI, 5'd13, 5'd14, 12'hFC1, '1, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_ORI, 5'd0, 5'd15, 12'h7FF, 64'd0, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM, F3_ANDI, 5'd16, 5'd17, 12'h7FF, '1, 0, 0));
    // op-imm-32
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_ADDI, 5'd18, 5'd19, 12'h001,
                                 64'h0000_0000_7FFF_FFFF, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_SLLI, 5'd20, 5'd21, 12'h01F, 64'd1, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_SLLI, 5'd20, 5'd21, 12'h020, 64'd1, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_SRXI, 5'd22, 5'd23, 12'h01F,
                                 64'hFFFF_FFFF_8000_0000, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_SRXI, 5'd24, 5'd25, 12'h41F,
                                 64'h0000_0000_8000_0000, 0, 0));
    directed.push_back(make_insn(OPC_OP_IMM_32, F3_SLTI, 5'd24, 5'd25, 12'h000, '1, 0, 0));
    // loads of every width and sign, plus the reserved width
    directed.push_back(make_insn(OPC_LOAD, F3_LB, 5'd1, 5'd2, 12'h800, 64'd0, 0, 64'h80));
    directed.push_back(make_insn(OPC_LOAD, F3_LH, 5'd1, 5'd2, 12'h7FF, '1, 0, 64'h8001));
    directed.push_back(make_insn(OPC_LOAD, F3_LW, 5'd1, 5'd2, 12'hFFF, 64'd0, 0, '1));
    directed.push_back(make_insn(OPC_LOAD, F3_LD, 5'd1, 5'd2, 12'h000, rand_word(), 0, '1));
    directed.push_back(make_insn(OPC_LOAD, F3_LBU, 5'd1, 5'd2, 12'h004, 64'd0, 0, '1));
    directed.push_back(make_insn(OPC_LOAD, F3_LHU, 5'd1, 5'd2, 12'h004, 64'd0, 0, '1));
    directed.push_back(make_insn(OPC_LOAD, F3_LWU, 5'd1, 5'd2, 12'h004, 64'd0, 0, '1));
    directed.push_back(make_insn(OPC_LOAD, F3_LRSVD, 5'd1, 5'd2, 12'h004, 64'd0, 0, '1));
    // jalr, system, fence, unknown opcode
    directed.push_back(make_insn(OPC_JALR, F3_JALR, 5'd1, 5'd5, 12'hFFF, 64'h1001,
                                 64'hFFFF_FFFF_FFFF_FFFC, 0));
    directed.push_back(make_insn(OPC_JALR, 3'd1, 5'd1, 5'd5, 12'h000, 64'h1000, 0, 0));
    directed.push_back(make_insn(OPC_SYSTEM, F3_PRIV, 5'd0, 5'd0, IMM_ECALL, 0, 0, 0));
    directed.push_back(make_insn(OPC_SYSTEM, F3_PRIV, 5'd0, 5'd0, IMM_EBREAK, 0, 0, 0));
    directed.push_back(make_insn(OPC_SYSTEM, F3_PRIV, 5'd1, 5'd0, IMM_ECALL, 0, 0, 0));
    directed.push_back(make_insn(OPC_MISC_MEM, 3'd1, 5'd3, 5'd4, 12'h0FF, 0, 0, 0));
    directed.push_back(make_insn(7'h7F, 3'd0, 5'd6, 5'd7, 12'h000, '1, '1, '1));

    foreach (directed[k]) begin
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 6));
      send_insn(directed[k]);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k < QUIET_FROM && ((k / 40) % 2 == 0) && $urandom_range(0, 2) == 0)
        pause($urandom_range(1, 6));
      send_insn(random_insn());
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/rie_pkg.sv
hdl/rie_exec.sv
hdl/rv64i_itype_execute_top.sv
test/itype_check_pkg.sv
test/tb.sv
